// ----- sv/sfr_pkg.sv -----
// sfr_pkg: shared constants, register indexes and types for the find-and-replace block
// no dependencies; imported by sfr_cell, sfr_emit and stream_find_and_replace_top
package sfr_pkg;

   localparam int MAX_PATTERN_DEF = 8;
   localparam int REPL_BYTES      = 8;
   localparam int MAX_RESULTS     = 8;
   localparam int RES_CW          = 4;

   typedef enum logic [1:0] {
      CSR_MATCH_PATTERN = 2'd0,
      CSR_MATCH_LENGTH  = 2'd1,
      CSR_REPL_PATTERN  = 2'd2,
      CSR_REPL_LENGTH   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      DROP_NONE  = 2'd0,
      DROP_ONE   = 2'd1,
      DROP_MATCH = 2'd2
   } drop_type;

   typedef struct packed {
      logic [RES_CW-1:0] rep_cnt;
      logic [RES_CW-1:0] total;
      logic              bare;
      logic              last;
   } job_type;

endpackage

// ----- sv/sfr_cell.sv -----
// sfr_cell: one slot of the pending window, holds a byte and compares it with its pattern byte
// depends on sfr_pkg
module sfr_cell (
   input  logic              clock,
   input  logic              load_en,
   input  logic              pick_new,
   input  logic [7:0]        new_byte,
   input  logic [7:0]        next_view,
   input  logic [7:0]        far_view,
   input  logic [7:0]        pat_byte,
   input  sfr_pkg::drop_type drop,
   output logic [7:0]        view,
   output logic [7:0]        d_next,
   output logic              eq
);
   import sfr_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   assign view = pick_new ? new_byte : byte_ff;
   assign eq   = (view == pat_byte);

   always_comb begin
      case (drop)
         DROP_ONE:   byte_in = next_view;
         DROP_MATCH: byte_in = far_view;
         default:    byte_in = view;
      endcase
   end

   assign d_next = byte_in;

   always_ff @(posedge clock) begin
      if (load_en) begin
         byte_ff <= byte_in;
      end
   end

endmodule

// ----- sv/sfr_emit.sv -----
// sfr_emit: result shifter, plays out the words of one decision one per cycle while rsp_ready is high
// depends on sfr_pkg
module sfr_emit #(
   parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  sfr_pkg::job_type                       job,
   input  logic [sfr_pkg::REPL_BYTES-1:0][7:0]    rep_bytes,
   input  logic [MAX_PATTERN-1:0][7:0]            flush_bytes,
   output logic                                   can_load,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [7:0]                             rsp_out_byte,
   output logic                                   rsp_byte_present,
   output logic                                   rsp_out_last
);
   import sfr_pkg::*;

   logic [RES_CW-1:0]               rem_ff, rem_in;
   logic [RES_CW-1:0]               rep_left_ff, rep_left_in;
   logic                            bare_ff, bare_in;
   logic                            last_ff, last_in;
   logic [REPL_BYTES-1:0][7:0]      rep_ff, rep_in;
   logic [MAX_PATTERN-1:0][7:0]     flush_ff, flush_in;
   logic                            pop;

   assign rsp_valid = (rem_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign can_load  = (rem_ff == '0) || ((rem_ff == RES_CW'(1)) && rsp_ready);

   assign rsp_out_byte     = bare_ff ? 8'd0 : ((rep_left_ff != '0) ? rep_ff[0] : flush_ff[0]);
   assign rsp_byte_present = !bare_ff;
   assign rsp_out_last     = last_ff && (rem_ff == RES_CW'(1));

   always_comb begin
      rem_in      = rem_ff;
      rep_left_in = rep_left_ff;
      bare_in     = bare_ff;
      last_in     = last_ff;
      rep_in      = rep_ff;
      flush_in    = flush_ff;
      if (load) begin
         rem_in      = job.total;
         rep_left_in = job.rep_cnt;
         bare_in     = job.bare;
         last_in     = job.last;
         rep_in      = rep_bytes;
         flush_in    = flush_bytes;
      end else if (pop) begin
         rem_in = rem_ff - RES_CW'(1);
         if (rep_left_ff != '0) begin
            rep_left_in = rep_left_ff - RES_CW'(1);
            for (int i = 0; i < REPL_BYTES - 1; i++) begin
               rep_in[i] = rep_ff[i+1];
            end
         end else begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
               flush_in[i] = flush_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff      <= '0;
         rep_left_ff <= '0;
         bare_ff     <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         rem_ff      <= rem_in;
         rep_left_ff <= rep_left_in;
         bare_ff     <= bare_in;
         last_ff     <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      rep_ff   <= rep_in;
      flush_ff <= flush_in;
   end

endmodule

// ----- sv/stream_find_and_replace_top.sv -----
// stream_find_and_replace_top: streaming find-and-replace over a byte stream, top level
// depends on sfr_pkg, sfr_cell and sfr_emit
//
// Takes one text byte per cycle, while req_ready is high, into a row of window cells; each cell
// compares its byte with its pattern byte, so a match decision is made in the cycle the byte is
// accepted and the window holds its place, shifts by one byte or by the whole match length. The
// decision's words (the replacement, a passed byte, and on the last byte the flushed window, at
// most eight) are loaded into the result shifter, which hands out one word per cycle while
// rsp_ready is high. A new byte is taken in the same cycle the shifter delivers its final word,
// so a stream where each byte yields at most one word runs at one byte per cycle while rsp_ready
// is high. A bare word with no byte and the last mark closes a text whose final step produced nothing.
module stream_find_and_replace_top #(
   parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_text_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_present,
   output logic        rsp_out_last,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import sfr_pkg::*;

   localparam int CW = $clog2(MAX_PATTERN + 1);

   logic [63:0]       match_pattern_ff;
   logic [3:0]        match_length_ff;
   logic [63:0]       repl_pattern_ff;
   logic [3:0]        repl_length_ff;
   logic [CW-1:0]     cnt_ff, cnt_in;

   logic              accept;
   logic              can_load;
   logic [3:0]        mlen4;
   logic [CW-1:0]     mlen;
   logic [RES_CW-1:0] rlen;
   logic [CW-1:0]     c1, c2;
   logic              decide, hit;
   drop_type          drop;
   logic [RES_CW-1:0] a_cnt;
   logic [RES_CW:0]   sum;
   job_type           job;

   logic [MAX_PATTERN-1:0][7:0] view, d_next, far_view, next_view;
   logic [MAX_PATTERN-1:0]      eq, in_rng, pick_new;
   logic [REPL_BYTES-1:0][7:0]  rep_bytes;

   assign accept    = req_valid && req_ready;
   assign req_ready = can_load;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         match_pattern_ff <= '0;
         match_length_ff  <= 4'd1;
         repl_pattern_ff  <= '0;
         repl_length_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MATCH_PATTERN: match_pattern_ff <= csr_wdata;
            CSR_MATCH_LENGTH:  match_length_ff  <= csr_wdata[3:0];
            CSR_REPL_PATTERN:  repl_pattern_ff  <= csr_wdata;
            CSR_REPL_LENGTH:   repl_length_ff   <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // clamp lengths
   always_comb begin
      if (match_length_ff == 4'd0) begin
         mlen4 = 4'd1;
      end else if (match_length_ff > 4'(MAX_PATTERN)) begin
         mlen4 = 4'(MAX_PATTERN);
      end else begin
         mlen4 = match_length_ff;
      end
      mlen = CW'(mlen4);
      rlen = (repl_length_ff > RES_CW'(REPL_BYTES)) ? RES_CW'(REPL_BYTES) : repl_length_ff;
   end

   // neighbour and far taps for the window shift
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pick_new[i]  = (cnt_ff == CW'(i));
         in_rng[i]    = (CW'(i) < mlen);
         next_view[i] = (i + 1 < MAX_PATTERN) ? view[(i + 1) % MAX_PATTERN] : 8'd0;
         far_view[i]  = 8'd0;
         for (int j = 0; j < MAX_PATTERN; j++) begin
            if (j == i + int'(mlen)) begin
               far_view[i] = view[j];
            end
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
         sfr_cell u_cell (
            .clock     (clock),
            .load_en   (accept),
            .pick_new  (pick_new[g]),
            .new_byte  (req_text_byte),
            .next_view (next_view[g]),
            .far_view  (far_view[g]),
            .pat_byte  (match_pattern_ff[8*g +: 8]),
            .drop      (drop),
            .view      (view[g]),
            .d_next    (d_next[g]),
            .eq        (eq[g])
         );
      end
   endgenerate

   // decision
   always_comb begin
      c1     = cnt_ff + CW'(1);
      decide = (c1 >= mlen);
      hit    = decide && (&(eq | ~in_rng));
      if (!decide) begin
         drop  = DROP_NONE;
         c2    = c1;
         a_cnt = '0;
      end else if (hit) begin
         drop  = DROP_MATCH;
         c2    = c1 - mlen;
         a_cnt = rlen;
      end else begin
         drop  = DROP_ONE;
         c2    = c1 - CW'(1);
         a_cnt = RES_CW'(1);
      end
      sum = {1'b0, a_cnt} + (req_text_last ? (RES_CW+1)'(c2) : '0);
      job.rep_cnt = a_cnt;
      job.bare    = req_text_last && (sum == '0);
      job.last    = req_text_last;
      if (job.bare) begin
         job.total = RES_CW'(1);
      end else if (sum > (RES_CW+1)'(MAX_RESULTS)) begin
         job.total = RES_CW'(MAX_RESULTS);
      end else begin
         job.total = sum[RES_CW-1:0];
      end
      rep_bytes = '0;
      if (hit) begin
         rep_bytes = repl_pattern_ff;
      end else begin
         rep_bytes[0] = view[0];
      end
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = req_text_last ? '0 : c2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   sfr_emit #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_emit (
      .clock            (clock),
      .reset            (reset),
      .load             (accept),
      .job              (job),
      .rep_bytes        (rep_bytes),
      .flush_bytes      (d_next),
      .can_load         (can_load),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_present (rsp_byte_present),
      .rsp_out_last     (rsp_out_last)
   );

`ifndef NO_ASSERTIONS
   a_cnt_below_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CW'(MAX_PATTERN))
      else $error("pending count reached window depth");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_text_last |=> cnt_ff == '0)
      else $error("window not empty after last byte");

   a_bare_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_present |-> rsp_out_last)
      else $error("bare word without last mark");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rsp_valid || rsp_ready)
      else $error("byte accepted while results still pending");
`endif

endmodule
